// File: hdl/mlk_pkg.sv
package mlk_pkg;

    localparam int UNIT_TICKS_W = 16;
    localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 16'd200;
    localparam logic [1:0] GAP_UNITS = 2'd3;
    localparam int NUM_LETTERS = 26;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_GAP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_TICK    = 2'd0,
        ST_LETTER  = 2'd1,
        ST_IGNORED = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_CHAR = 1'b1
    } op_t;

    typedef struct packed {
        phase_t                  phase;
        logic [4:0]              letter_index;
        logic [2:0]              symbol_position;
        logic [1:0]              units_left;
        logic [UNIT_TICKS_W-1:0] tick_count;
    } keyer_state_t;

    // symbol lengths in units, first symbol in the top bits, 0 ends the pattern
    localparam logic [7:0] MORSE_TABLE [NUM_LETTERS] = '{
        {2'd1, 2'd3, 2'd0, 2'd0}, {2'd3, 2'd1, 2'd1, 2'd1}, {2'd3, 2'd1, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd1, 2'd0}, {2'd1, 2'd0, 2'd0, 2'd0}, {2'd1, 2'd1, 2'd3, 2'd1},
        {2'd3, 2'd3, 2'd1, 2'd0}, {2'd1, 2'd1, 2'd1, 2'd1}, {2'd1, 2'd1, 2'd0, 2'd0},
        {2'd1, 2'd3, 2'd3, 2'd3}, {2'd3, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd3, 2'd1, 2'd1},
        {2'd3, 2'd3, 2'd0, 2'd0}, {2'd3, 2'd1, 2'd0, 2'd0}, {2'd3, 2'd3, 2'd3, 2'd0},
        {2'd1, 2'd3, 2'd3, 2'd1}, {2'd3, 2'd3, 2'd1, 2'd3}, {2'd1, 2'd3, 2'd1, 2'd0},
        {2'd1, 2'd1, 2'd1, 2'd0}, {2'd3, 2'd0, 2'd0, 2'd0}, {2'd1, 2'd1, 2'd3, 2'd0},
        {2'd1, 2'd1, 2'd1, 2'd3}, {2'd1, 2'd3, 2'd3, 2'd0}, {2'd3, 2'd1, 2'd1, 2'd3},
        {2'd3, 2'd1, 2'd3, 2'd3}, {2'd3, 2'd3, 2'd1, 2'd1}
    };

    function automatic logic [1:0] morse_len(input logic [4:0] idx, input logic [1:0] pos);
        logic [7:0] row;
        logic [1:0] len;
        row = (idx < 5'(NUM_LETTERS)) ? MORSE_TABLE[idx] : 8'd0;
        case (pos)
            2'd0: len = row[7:6];
            2'd1: len = row[5:4];
            2'd2: len = row[3:2];
            2'd3: len = row[1:0];
            default: len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/mlk_step.sv
module mlk_step (
    input  mlk_pkg::keyer_state_t           cur,
    input  logic                            op,
    input  logic [7:0]                      ch,
    input  logic [mlk_pkg::UNIT_TICKS_W-1:0] unit_ticks,
    output mlk_pkg::keyer_state_t           nxt,
    output mlk_pkg::status_t                status
);
    import mlk_pkg::*;

    logic [UNIT_TICKS_W-1:0] limit;
    logic [UNIT_TICKS_W-1:0] count;
    logic                    unit_done;
    logic [1:0]              units_dec;
    logic [2:0]              pos_inc;
    logic [1:0]              next_len;
    logic                    is_upper;
    logic                    is_lower;
    logic [4:0]              letter;

    assign limit     = (unit_ticks == '0) ? UNIT_TICKS_W'(1) : unit_ticks;
    assign count     = cur.tick_count + UNIT_TICKS_W'(1);
    assign unit_done = (count >= limit) || (count == '0);
    assign units_dec = cur.units_left - 2'd1;
    assign pos_inc   = cur.symbol_position + 3'd1;
    assign next_len  = pos_inc[2] ? 2'd0 : morse_len(cur.letter_index, pos_inc[1:0]);

    assign is_upper = ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    assign is_lower = ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    assign letter   = is_upper ? 5'(ch - CHAR_UPPER_A) : 5'(ch - CHAR_LOWER_A);

    always_comb begin
        nxt    = cur;
        status = ST_TICK;
        if (op == OP_TICK) begin
            if (cur.phase != PH_IDLE) begin
                if (unit_done) begin
                    nxt.tick_count = '0;
                    nxt.units_left = units_dec;
                    if (units_dec == 2'd0) begin
                        case (cur.phase)
                            PH_MARK: begin
                                nxt.phase      = PH_SPACE;
                                nxt.units_left = 2'd1;
                            end
                            PH_SPACE: begin
                                if (next_len != 2'd0) begin
                                    nxt.phase           = PH_MARK;
                                    nxt.symbol_position = pos_inc;
                                    nxt.units_left      = next_len;
                                end else begin
                                    nxt.phase      = PH_GAP;
                                    nxt.units_left = GAP_UNITS;
                                end
                            end
                            default: begin
                                nxt.phase           = PH_IDLE;
                                nxt.units_left      = 2'd0;
                                nxt.symbol_position = 3'd0;
                            end
                        endcase
                    end
                end else begin
                    nxt.tick_count = count;
                end
            end
        end else if (cur.phase != PH_IDLE) begin
            status = ST_REJECT;
        end else if (!is_upper && !is_lower) begin
            status = ST_IGNORED;
        end else begin
            nxt.letter_index    = letter;
            nxt.symbol_position = 3'd0;
            nxt.tick_count      = '0;
            nxt.phase           = PH_MARK;
            nxt.units_left      = morse_len(letter, 2'd0);
            status              = ST_LETTER;
        end
    end

endmodule

// File: hdl/morse_letter_keyer_top.sv
// Morse letter keyer. Each input beat is a time tick (s_tuser 0) or a character
// (s_tuser 1, ASCII in s_tdata). A letter starts its Morse pattern: dot lit one
// unit, dash three, each followed by one dark unit, then three dark units after
// the letter; a character arriving while a letter plays is rejected. unit_ticks
// (cfg_wdata, written on cfg_we, reset 200, 0 acts as 1) sets ticks per unit; the
// user must write it only while idle (the block does not check). One beat is taken
// every clock; its result appears on the m_ side the cycle after acceptance, from
// one output register; s_tready drops only while it holds a result not yet taken.
module morse_letter_keyer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mlk_pkg::UNIT_TICKS_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // character
    input  logic                             s_tuser,   // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // led, busy_res, zero pad
    output logic [1:0]                       m_tuser    // status
);
    import mlk_pkg::*;

    logic [UNIT_TICKS_W-1:0] unit_ticks_reg;
    keyer_state_t            state_reg;
    keyer_state_t            state_next;
    status_t                 status_next;
    logic                    m_tvalid_reg;
    logic                    led_reg;
    logic                    busy_reg;
    status_t                 status_reg;
    logic                    s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    mlk_step u_step (
        .cur        (state_reg),
        .op         (s_tuser),
        .ch         (s_tdata),
        .unit_ticks (unit_ticks_reg),
        .nxt        (state_next),
        .status     (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end else if (cfg_we) begin
            unit_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, letter_index: '0, symbol_position: '0,
                           units_left: '0, tick_count: '0};
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            led_reg    <= (state_next.phase == PH_MARK);
            busy_reg   <= (state_next.phase != PH_IDLE);
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, busy_reg, led_reg};
    assign m_tuser  = status_reg;

    // led only while a letter plays
    a_led_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("led lit while not busy");

    // a playing letter always has units pending
    a_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != PH_IDLE) |-> (state_reg.units_left != 2'd0))
        else $error("active phase with no units left");

    // a character beat while busy comes back rejected
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser && state_reg.phase != PH_IDLE)
            |=> (m_tuser == ST_REJECT && m_tdata[1]))
        else $error("busy character not rejected");

    // idle state holds its symbol position cleared
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_IDLE) |-> (state_reg.symbol_position == 3'd0))
        else $error("idle with symbol position set");

endmodule

// File: tb/tb_morse_letter_keyer_top.sv
`timescale 1ns / 1ps

module tb_morse_letter_keyer_top;
    import mlk_pkg::*;

    localparam int RANDOM_BEATS = 1150;
    localparam int CALM_FROM    = 1050;

    typedef struct {
        logic    led;
        logic    busy;
        status_t status;
    } keyer_result_t;

    // units per symbol for A..Z, 0 ends the pattern
    localparam logic [1:0] SYMBOL_UNITS [NUM_LETTERS][4] = '{
        '{2'd1, 2'd3, 2'd0, 2'd0}, '{2'd3, 2'd1, 2'd1, 2'd1}, '{2'd3, 2'd1, 2'd3, 2'd1},
        '{2'd3, 2'd1, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd3, 2'd1},
        '{2'd3, 2'd3, 2'd1, 2'd0}, '{2'd1, 2'd1, 2'd1, 2'd1}, '{2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd1, 2'd3, 2'd3, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd1, 2'd1},
        '{2'd3, 2'd3, 2'd0, 2'd0}, '{2'd3, 2'd1, 2'd0, 2'd0}, '{2'd3, 2'd3, 2'd3, 2'd0},
        '{2'd1, 2'd3, 2'd3, 2'd1}, '{2'd3, 2'd3, 2'd1, 2'd3}, '{2'd1, 2'd3, 2'd1, 2'd0},
        '{2'd1, 2'd1, 2'd1, 2'd0}, '{2'd3, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd3, 2'd0},
        '{2'd1, 2'd1, 2'd1, 2'd3}, '{2'd1, 2'd3, 2'd3, 2'd0}, '{2'd3, 2'd1, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd3}, '{2'd3, 2'd3, 2'd1, 2'd1}
    };

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [UNIT_TICKS_W-1:0] cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata   = 8'h00;  // character
    logic                    s_tuser   = 1'b0;   // operation
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [7:0]              m_tdata;            // led, busy_res, zero pad
    logic [1:0]              m_tuser;            // status

    // predicted keyer state
    logic [UNIT_TICKS_W-1:0] unit_len   = UNIT_TICKS_RESET;
    phase_t                  key_phase  = PH_IDLE;
    logic [4:0]              key_letter = '0;
    logic [2:0]              key_sym    = '0;
    logic [1:0]              key_units  = '0;
    logic [UNIT_TICKS_W-1:0] key_ticks  = '0;

    keyer_result_t pending_results [$];
    int            errors     = 0;
    int            beats_sent = 0;
    bit            calm       = 1'b0;

    morse_letter_keyer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void predict_keyer_result(op_t op, logic [7:0] ch);
        keyer_result_t           res;
        logic [UNIT_TICKS_W-1:0] limit;
        logic [UNIT_TICKS_W-1:0] count;
        logic [2:0]              next_sym;
        int                      idx;
        res.status = ST_TICK;
        idx = -1;
        if (op == OP_TICK) begin
            if (key_phase != PH_IDLE) begin
                limit = (unit_len == '0) ? UNIT_TICKS_W'(1) : unit_len;
                count = key_ticks + 1'b1;
                if (count >= limit || count == '0) begin
                    key_ticks = '0;
                    key_units = key_units - 2'd1;
                    if (key_units == 2'd0) begin
                        case (key_phase)
                            PH_MARK: begin
                                key_phase = PH_SPACE;
                                key_units = 2'd1;
                            end
                            PH_SPACE: begin
                                next_sym = key_sym + 3'd1;
                                if (next_sym < 3'd4 &&
                                    SYMBOL_UNITS[key_letter][next_sym[1:0]] != 2'd0) begin
                                    key_sym   = next_sym;
                                    key_phase = PH_MARK;
                                    key_units = SYMBOL_UNITS[key_letter][next_sym[1:0]];
                                end else begin
                                    key_phase = PH_GAP;
                                    key_units = GAP_UNITS;
                                end
                            end
                            default: begin
                                key_phase = PH_IDLE;
                                key_units = 2'd0;
                                key_sym   = 3'd0;
                            end
                        endcase
                    end
                end else begin
                    key_ticks = count;
                end
            end
        end else if (key_phase != PH_IDLE) begin
            res.status = ST_REJECT;
        end else begin
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
                idx = int'(ch - CHAR_UPPER_A);
            else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
                idx = int'(ch - CHAR_LOWER_A);
            if (idx < 0) begin
                res.status = ST_IGNORED;
            end else begin
                key_letter = 5'(idx);
                key_sym    = 3'd0;
                key_ticks  = '0;
                key_phase  = PH_MARK;
                key_units  = SYMBOL_UNITS[idx][0];
                res.status = ST_LETTER;
            end
        end
        res.led  = (key_phase == PH_MARK);
        res.busy = (key_phase != PH_IDLE);
        pending_results.push_back(res);
    endfunction

    // called at a rising edge; returns at the edge that accepts the beat
    task automatic send_beat(op_t op, logic [7:0] ch);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_keyer_result(op, ch);
        beats_sent++;
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // only called with the pipeline drained
    task automatic set_unit_ticks(logic [UNIT_TICKS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        unit_len = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_tick();
        send_beat(OP_CHAR, 8'h40);
        send_beat(OP_CHAR, 8'h5B);
        send_beat(OP_CHAR, 8'h60);
        send_beat(OP_CHAR, 8'h7B);
        send_beat(OP_CHAR, "T");
        send_tick();
        send_beat(OP_CHAR, "q");
        send_beat(OP_CHAR, 8'hFF);
        wait_all_results();
    endtask

    task automatic test_zero_unit_length();
        set_unit_ticks('0);
        while (key_phase != PH_IDLE) send_tick();
        // four-symbol letter still gets the trailing gap
        send_beat(OP_CHAR, "h");
        while (key_phase != PH_IDLE) send_tick();
        send_tick();
        wait_all_results();
    endtask

    task automatic test_unit_change_mid_unit();
        set_unit_ticks('1);
        send_beat(OP_CHAR, "e");
        send_tick();
        send_tick();
        wait_all_results();
        set_unit_ticks(UNIT_TICKS_W'(1));
        send_tick();
        send_tick();
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int useful;
        int phase_left;
        int pick;
        logic [7:0] base;
        useful = 0;
        while (useful < RANDOM_BEATS) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                set_unit_ticks('0);
            else if (pick < 8)
                set_unit_ticks(UNIT_TICKS_W'(1));
            else if (pick < 12)
                set_unit_ticks(UNIT_TICKS_W'(2));
            else if (pick < 15)
                set_unit_ticks(UNIT_TICKS_W'(3));
            else if (pick < 18)
                set_unit_ticks(UNIT_TICKS_W'($urandom_range(4, 7)));
            else if (pick == 18)
                set_unit_ticks('1);
            else
                set_unit_ticks(UNIT_TICKS_W'($urandom_range(8, 65534)));
            phase_left = $urandom_range(40, 120);
            while (phase_left > 0 && useful < RANDOM_BEATS) begin
                if (useful >= CALM_FROM)
                    calm = 1'b1;
                pick = $urandom_range(0, 99);
                if (key_phase != PH_IDLE) begin
                    useful++;
                    if (pick < 88)
                        send_tick();
                    else
                        send_beat(OP_CHAR, 8'($urandom_range(0, 255)));
                end else if (pick < 70) begin
                    useful++;
                    base = $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A;
                    send_beat(OP_CHAR, base + 8'($urandom_range(0, 25)));
                end else if (pick < 85) begin
                    send_tick();
                end else begin
                    send_beat(OP_CHAR, 8'($urandom_range(0, 255)));
                end
                phase_left--;
            end
            wait_all_results();
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (!calm && $urandom_range(0, 2) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge aclk);
                end
                m_tready <= 1'b1;
                // now and then a long stretch with no stall
                if ($urandom_range(0, 9) == 0)
                    repeat (60) @(posedge aclk);
                else
                    repeat ($urandom_range(0, 23)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        keyer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, tdata %h tuser %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.led) begin
                    $display("%0t: led expected %b actual %b", $time, want.led, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.busy) begin
                    $display("%0t: busy expected %b actual %b", $time, want.busy, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[7:2] !== 6'd0) begin
                    $display("%0t: tdata pad expected %h actual %h", $time, 6'd0, m_tdata[7:2]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_unit_length();
        test_unit_change_mid_unit();
        test_random_traffic();
        wait_all_results();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
